// File: hdl/trrs_pkg.sv
// Shared types, codes and the ordering rule of the tile read request scheduler.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package trrs_pkg;

  typedef enum logic [1:0] {
    FUNC_PUSH   = 2'd0,
    FUNC_POP    = 2'd1,
    FUNC_CANCEL = 2'd2,
    FUNC_ABORT  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_EMPTY     = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_e;

  // The owner field is two bits wide, so at most four owners can ever hold entries.
  localparam int NumPicks = 4;

  typedef struct packed {
    func_e       func;
    logic [1:0]  owner;
    logic [4:0]  level;
    logic [15:0] column;
    logic [15:0] row;
    logic [31:0] target_id;
  } cmd_t;

  typedef struct packed {
    logic [31:0] id;
    logic [1:0]  owner;
    logic [4:0]  level;
    logic [15:0] column;
    logic [15:0] row;
  } entry_t;

  typedef struct packed {
    logic        found;
    logic [31:0] id;
    logic [4:0]  level;
    logic        canceled;
    logic [15:0] column;
    logic [15:0] row;
  } pick_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] request_id;
    logic [1:0]  served_owner;
    logic [4:0]  served_level;
    logic [15:0] served_column;
    logic [15:0] served_row;
    logic        was_canceled;
    logic [4:0]  removed_count;
  } result_t;

  // True when request a goes ahead of request b of the same owner.
  function automatic logic beats(input logic a_can, input logic [4:0] a_lvl,
                                 input logic [31:0] a_id, input logic b_can,
                                 input logic [4:0] b_lvl, input logic [31:0] b_id);
    logic r;
    if (a_can && b_can) begin
      r = a_id < b_id;
    end else if (a_can != b_can) begin
      r = a_can;
    end else if (a_lvl != b_lvl) begin
      r = a_lvl < b_lvl;
    end else begin
      r = a_id > b_id;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hdl/trrs_front.sv
// Front end of the scheduler: accepts commands, folds the owner and queues them.
// Depends on trrs_pkg.
`default_nettype none

module trrs_front #(
  parameter int NUM_OWNERS = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  trrs_pkg::cmd_t cmd_i,
  output logic           cmd_valid_o,
  output trrs_pkg::cmd_t cmd_o,
  input  logic           cmd_take_i
);
  import trrs_pkg::*;

  cmd_t       slot_q [2];
  cmd_t       folded;
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push;
  logic [1:0] own;

  // Owner numbers at or above the owner count are folded back into range.
  always_comb begin
    own = cmd_i.owner;
    for (int k = 0; k < 3; k++) begin
      if (32'(own) >= NUM_OWNERS) own = own - 2'(NUM_OWNERS);
    end
    folded       = cmd_i;
    folded.owner = own;
  end

  assign in_stall_o  = (count_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_ptr_q] <= folded;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (cmd_take_i) rd_ptr_q <= !rd_ptr_q;
      count_q <= count_q + 2'(push) - 2'(cmd_take_i);
    end
  end

endmodule

`default_nettype wire

// File: hdl/trrs_back.sv
// Back end of the scheduler: entry store, scan sequencer, owner arbitration and
// the result register. Depends on trrs_pkg.
`default_nettype none

module trrs_back #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  trrs_pkg::cmd_t    cmd_i,
  output logic              cmd_take_o,
  output logic              res_valid_o,
  input  logic              res_stall_i,
  output trrs_pkg::result_t res_o
);
  import trrs_pkg::*;

  localparam int IdxW = $clog2(QUEUE_DEPTH);
  localparam int CntW = IdxW + 1;
  localparam int SelW = $clog2(NumPicks);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_SELECT, S_DONE} state_e;

  state_e                 state_q;
  cmd_t                   cmd_q;
  logic [CntW-1:0]        idx_q;
  logic                   rd_vld_q;
  logic [IdxW-1:0]        rd_idx_q;
  logic [QUEUE_DEPTH-1:0] valid_q, canceled_q;
  pick_t                  pick_q [NumPicks];
  logic [IdxW-1:0]        pick_idx_q [NumPicks];
  logic [SelW-1:0]        sel_q;
  pick_t                  best_q;
  logic [IdxW-1:0]        best_idx_q;
  logic [1:0]             best_owner_q;
  logic                   free_found_q;
  logic [IdxW-1:0]        free_idx_q;
  logic                   found_q;
  logic [CntW-1:0]        count_q;
  logic [31:0]            next_id_q;
  logic                   res_valid_q;
  result_t                res_q, res_d;

  entry_t                 mem_q [QUEUE_DEPTH];
  entry_t                 rd_data_q;

  logic            rd_en, wr_en, res_free, e_valid, e_can, e_beats;
  logic [IdxW-1:0] rd_addr;
  pick_t           cur_pick, sel_pick;

  assign rd_en    = (state_q == S_SCAN) && (idx_q < CntW'(QUEUE_DEPTH));
  assign rd_addr  = idx_q[IdxW-1:0];
  assign e_valid  = valid_q[rd_idx_q];
  assign e_can    = canceled_q[rd_idx_q];
  assign cur_pick = pick_q[rd_data_q.owner];
  assign sel_pick = pick_q[sel_q];
  assign e_beats  = !cur_pick.found ||
                    beats(e_can, rd_data_q.level, rd_data_q.id,
                          cur_pick.canceled, cur_pick.level, cur_pick.id);
  assign res_free = !res_valid_q || !res_stall_i;
  assign wr_en    = (state_q == S_DONE) && res_free && (cmd_q.func == FUNC_PUSH) &&
                    free_found_q;
  assign cmd_take_o  = (state_q == S_IDLE) && cmd_valid_i;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_comb begin
    res_d = '0;
    unique case (cmd_q.func)
      FUNC_PUSH: begin
        if (free_found_q) begin
          res_d.status     = STAT_OK;
          res_d.request_id = next_id_q;
        end else begin
          res_d.status = STAT_FULL;
        end
      end
      FUNC_POP: begin
        if (best_q.found) begin
          res_d.status        = STAT_OK;
          res_d.request_id    = best_q.id;
          res_d.served_owner  = best_owner_q;
          res_d.served_level  = best_q.level;
          res_d.served_column = best_q.column;
          res_d.served_row    = best_q.row;
          res_d.was_canceled  = best_q.canceled;
        end else begin
          res_d.status = STAT_EMPTY;
        end
      end
      FUNC_CANCEL: begin
        res_d.status     = found_q ? STAT_OK : STAT_NOT_FOUND;
        res_d.request_id = cmd_q.target_id;
      end
      FUNC_ABORT: begin
        res_d.status        = STAT_OK;
        res_d.removed_count = (32'(count_q) > 31) ? 5'd31 : 5'(count_q);
      end
      default: res_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[free_idx_q] <= '{id: next_id_q, owner: cmd_q.owner, level: cmd_q.level,
                             column: cmd_q.column, row: cmd_q.row};
    end
    if (rd_en) rd_data_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cmd_q        <= '0;
      idx_q        <= '0;
      rd_vld_q     <= 1'b0;
      rd_idx_q     <= '0;
      valid_q      <= '0;
      canceled_q   <= '0;
      for (int p = 0; p < NumPicks; p++) begin
        pick_q[p]     <= '0;
        pick_idx_q[p] <= '0;
      end
      sel_q        <= '0;
      best_q       <= '0;
      best_idx_q   <= '0;
      best_owner_q <= '0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
      found_q      <= 1'b0;
      count_q      <= '0;
      next_id_q    <= 32'd1;
      res_valid_q  <= 1'b0;
      res_q        <= '0;
    end else begin
      if (res_valid_q && !res_stall_i && (state_q != S_DONE)) res_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            cmd_q        <= cmd_i;
            idx_q        <= '0;
            free_found_q <= 1'b0;
            found_q      <= 1'b0;
            count_q      <= '0;
            for (int p = 0; p < NumPicks; p++) pick_q[p].found <= 1'b0;
            state_q      <= S_SCAN;
          end
        end
        S_SCAN: begin
          rd_vld_q <= rd_en;
          rd_idx_q <= rd_addr;
          if (rd_en) idx_q <= idx_q + CntW'(1);
          if (rd_vld_q) begin
            if (!e_valid) begin
              if (!free_found_q) begin
                free_found_q <= 1'b1;
                free_idx_q   <= rd_idx_q;
              end
            end else begin
              case (cmd_q.func)
                FUNC_POP: begin
                  if (e_beats) begin
                    pick_q[rd_data_q.owner] <= '{found: 1'b1, id: rd_data_q.id,
                                                 level: rd_data_q.level, canceled: e_can,
                                                 column: rd_data_q.column,
                                                 row: rd_data_q.row};
                    pick_idx_q[rd_data_q.owner] <= rd_idx_q;
                  end
                end
                FUNC_CANCEL: begin
                  if (rd_data_q.id == cmd_q.target_id) begin
                    canceled_q[rd_idx_q] <= 1'b1;
                    found_q              <= 1'b1;
                  end
                end
                FUNC_ABORT: begin
                  if (rd_data_q.owner == cmd_q.owner) begin
                    valid_q[rd_idx_q] <= 1'b0;
                    count_q           <= count_q + CntW'(1);
                  end
                end
                default: ;
              endcase
            end
          end
          if (!rd_en && !rd_vld_q) begin
            sel_q        <= '0;
            best_q.found <= 1'b0;
            state_q      <= (cmd_q.func == FUNC_POP) ? S_SELECT : S_DONE;
          end
        end
        S_SELECT: begin
          if (sel_pick.found && (!best_q.found || sel_pick.id < best_q.id)) begin
            best_q       <= sel_pick;
            best_idx_q   <= pick_idx_q[sel_q];
            best_owner_q <= 2'(sel_q);
          end
          if (sel_q == SelW'(NumPicks - 1)) begin
            state_q <= S_DONE;
          end else begin
            sel_q <= sel_q + SelW'(1);
          end
        end
        S_DONE: begin
          if (res_free) begin
            res_q       <= res_d;
            res_valid_q <= 1'b1;
            state_q     <= S_IDLE;
            if (wr_en) begin
              valid_q[free_idx_q]    <= 1'b1;
              canceled_q[free_idx_q] <= 1'b0;
              next_id_q              <= next_id_q + 32'd1;
            end
            if (cmd_q.func == FUNC_POP && best_q.found) valid_q[best_idx_q] <= 1'b0;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= CntW'(QUEUE_DEPTH))
    else $error("scan counter ran past the queue depth");
  a_read_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> state_q == S_SCAN)
    else $error("entry read pending outside the scan");
  a_id_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> next_id_q == $past(next_id_q) + 32'd1)
    else $error("id counter did not advance on a stored push");
  a_take_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_take_o |-> !rd_vld_q && !res_valid_q || !rd_vld_q)
    else $error("new command taken with a read still in flight");
`endif

endmodule

`default_nettype wire

// File: hdl/tile_read_request_scheduler.sv
// Top level of the tile read request scheduler: front command queue and back end.
// Depends on trrs_pkg, trrs_front and trrs_back.
`default_nettype none

// The scheduler holds up to QUEUE_DEPTH pending tile read requests and takes one
// command per item: push, pop next, cancel by id or abort owner. Every command
// gives exactly one result item. A push stores the request in the lowest free
// entry under the next id of a shared counter that starts at one. A pop picks,
// for each owner, its oldest canceled request or else its lowest level request
// (newest on a tie), then serves the owner whose pick has the smallest id, the
// lower owner on equal ids. Commands are accepted into a two item queue, so the
// sender keeps going while the back end works and while a result waits to be
// taken, until both items are held. The back end scans the entry store through
// its single read port, one entry per cycle; each command is taken, then
// scanned with the last read drained, then its result is loaded, and a pop
// arbitrates across owners before the load. A stalled result holds the back
// end in its done state until the result register frees up.
module tile_read_request_scheduler #(
  parameter int QUEUE_DEPTH = 16,
  parameter int NUM_OWNERS  = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [1:0]  owner_i,
  input  logic [4:0]  level_i,
  input  logic [15:0] tile_column_i,
  input  logic [15:0] tile_row_i,
  input  logic [31:0] target_id_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [31:0] request_id_o,
  output logic [1:0]  served_owner_o,
  output logic [4:0]  served_level_o,
  output logic [15:0] served_column_o,
  output logic [15:0] served_row_o,
  output logic        was_canceled_o,
  output logic [4:0]  removed_count_o
);
  import trrs_pkg::*;

  cmd_t    in_cmd, cmd;
  logic    cmd_valid, cmd_take;
  result_t res;

  // Gather the input fields into one command word.
  assign in_cmd = '{func: func_e'(func_i), owner: owner_i, level: level_i,
                    column: tile_column_i, row: tile_row_i, target_id: target_id_i};

  trrs_front #(.NUM_OWNERS(NUM_OWNERS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (in_cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_take_i  (cmd_take)
  );

  trrs_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_take_o  (cmd_take),
    .res_valid_o (out_valid_o),
    .res_stall_i (out_stall_i),
    .res_o       (res)
  );

  // The result register in the back end drives the output fields directly.
  assign status_o        = res.status;
  assign request_id_o    = res.request_id;
  assign served_owner_o  = res.served_owner;
  assign served_level_o  = res.served_level;
  assign served_column_o = res.served_column;
  assign served_row_o    = res.served_row;
  assign was_canceled_o  = res.was_canceled;
  assign removed_count_o = res.removed_count;

endmodule

`default_nettype wire
